// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands, sampled on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define FEG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define FEG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, live through reset
`define FEG_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/feg_pkg.sv =====
package feg_pkg;

   localparam int GRID_WIDTH  = 60;
   localparam int GRID_HEIGHT = 80;
   localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W      = $clog2(GRID_CELLS);
   localparam int COL_W       = $clog2(GRID_WIDTH);
   localparam int HEAT_W      = 5;
   localparam int COLOR_W     = 15;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GRID_CELLS - 1);
   localparam logic [ADDR_W-1:0] SEED_BASE = ADDR_W'((GRID_HEIGHT - 1) * GRID_WIDTH);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_WIDTH);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(GRID_WIDTH - 1);
   localparam logic [HEAT_W-1:0] HEAT_MAX  = 5'd31;
   localparam logic [31:0]       RNG_SEED  = 32'h82BD18AC;

   typedef enum logic [1:0] {
      ACT_SEED = 2'd0,
      ACT_PASS = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } feg_action_type;

   typedef struct packed {
      feg_action_type action;
      logic [5:0]     col;
      logic [6:0]     row;
   } feg_req_type;

   typedef struct packed {
      logic [HEAT_W-1:0]  heat;
      logic [COLOR_W-1:0] color;
   } feg_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [HEAT_W-1:0] heat;
   } feg_res_type;

   // RGB555, red in the low five bits
   localparam logic [COLOR_W-1:0] PALETTE [32] = '{
      {5'd0,  5'd0,  5'd0},  {5'd0,  5'd0,  5'd3},  {5'd0,  5'd0,  5'd6},  {5'd0,  5'd0,  5'd9},
      {5'd0,  5'd0,  5'd12}, {5'd0,  5'd0,  5'd16}, {5'd0,  5'd0,  5'd20}, {5'd0,  5'd0,  5'd24},
      {5'd0,  5'd0,  5'd28}, {5'd0,  5'd1,  5'd31}, {5'd0,  5'd3,  5'd31}, {5'd0,  5'd5,  5'd31},
      {5'd0,  5'd7,  5'd31}, {5'd0,  5'd9,  5'd31}, {5'd0,  5'd11, 5'd31}, {5'd0,  5'd13, 5'd31},
      {5'd0,  5'd15, 5'd31}, {5'd0,  5'd17, 5'd31}, {5'd0,  5'd19, 5'd31}, {5'd0,  5'd21, 5'd31},
      {5'd0,  5'd23, 5'd31}, {5'd0,  5'd25, 5'd31}, {5'd0,  5'd27, 5'd31}, {5'd0,  5'd29, 5'd31},
      {5'd0,  5'd31, 5'd31}, {5'd3,  5'd31, 5'd31}, {5'd6,  5'd31, 5'd31}, {5'd10, 5'd31, 5'd31},
      {5'd14, 5'd31, 5'd31}, {5'd19, 5'd31, 5'd31}, {5'd25, 5'd31, 5'd31}, {5'd31, 5'd31, 5'd31}
   };

   function automatic logic [COLOR_W-1:0] feg_color(input logic [HEAT_W-1:0] heat);
      return PALETTE[heat];
   endfunction

   // xorshift32, shifts 13, 17, 5
   function automatic logic [31:0] feg_rng_next(input logic [31:0] s);
      logic [31:0] a;
      logic [31:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

// ===== rtl/core/fire_effect_grid.sv =====
// channel | ports                         | moves
// --------+-------------------------------+-------------------------------
// request | req_valid, req_stall, req_data | action, col, row
// result  | rsp_valid, rsp_stall, rsp_data | heat, colour
//
// One request in flight; the grid sits in a single RAM, one cell per cycle.
// Seed: fills the bottom row with HEAT_MAX. Read: fetches one cell. Unused action: answers heat 0.
// Pass: works through rows 1 to GRID_HEIGHT - 1, one RAM read and at most one write per cell.
// After reset a clearing sweep over all GRID_CELLS cells holds req_stall high.
// A stalled result stays in the output register; the next result waits for it.
module fire_effect_grid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  feg_pkg::feg_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output feg_pkg::feg_rsp_type rsp_data
);
   import feg_pkg::*;

   feg_res_type res;
   logic        res_take;
   logic        rsp_valid_ff, rsp_valid_in;
   feg_rsp_type rsp_data_ff, rsp_data_in;

   feg_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .res       (res),
      .res_take  (res_take)
   );

   assign res_take     = res.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (res_take) begin
         rsp_data_in.heat  = res.heat;
         rsp_data_in.color = feg_color(res.heat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/feg_heat_ram.sv =====
module feg_heat_ram #(
   parameter int DEPTH = 4800,
   parameter int WIDTH = 5
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/feg_engine.sv =====
module feg_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  feg_pkg::feg_req_type req_data,
   output logic                req_stall,
   output feg_pkg::feg_res_type res,
   input  logic                res_take
);
   import feg_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SEED  = 6'b000100,
      ST_PASS  = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DONE  = 6'b100000
   } feg_state_type;

   feg_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [COL_W-1:0]  x_ff, x_in;
   logic              run_ff, run_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]  s1_x_ff, s1_x_in;
   logic [ADDR_W-1:0] s1_up_ff, s1_up_in;
   logic [31:0]       rng_ff, rng_in;
   logic [HEAT_W-1:0] heat_ff, heat_in;
   logic              rd_ok_ff, rd_ok_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [HEAT_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [HEAT_W-1:0] rd_data;

   logic [31:0]       rnd;
   logic [23:0]       req_lin;
   logic              req_ok;

   feg_heat_ram #(
      .DEPTH (GRID_CELLS),
      .WIDTH (HEAT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rnd       = feg_rng_next(rng_ff);
   assign req_lin   = 24'(req_data.row) * 24'(GRID_WIDTH) + 24'(req_data.col);
   assign req_ok    = (16'(req_data.col) < 16'(GRID_WIDTH)) &&
                      (16'(req_data.row) < 16'(GRID_HEIGHT));
   assign req_stall = (state_ff != ST_IDLE);
   assign res.valid = (state_ff == ST_DONE);
   assign res.heat  = heat_ff;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      x_in        = x_ff;
      run_in      = run_ff;
      s1_valid_in = 1'b0;
      s1_x_in     = s1_x_ff;
      s1_up_in    = s1_up_ff;
      rng_in      = rng_ff;
      heat_in     = heat_ff;
      rd_ok_in    = rd_ok_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.action)
                  ACT_SEED: begin
                     addr_in  = SEED_BASE;
                     heat_in  = '0;
                     state_in = ST_SEED;
                  end
                  ACT_PASS: begin
                     addr_in  = ROW_STEP;
                     x_in     = '0;
                     run_in   = 1'b1;
                     heat_in  = '0;
                     state_in = ST_PASS;
                  end
                  ACT_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(req_lin);
                     rd_ok_in = req_ok;
                     state_in = ST_READ;
                  end
                  ACT_NONE: begin
                     heat_in  = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEED: begin
            wr_en   = 1'b1;
            wr_data = HEAT_MAX;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DONE;
            end
         end
         ST_PASS: begin
            if (run_ff) begin
               rd_en       = 1'b1;
               s1_valid_in = 1'b1;
               s1_x_in     = x_ff;
               s1_up_in    = addr_ff - ROW_STEP;
               addr_in     = addr_ff + ADDR_W'(1);
               x_in        = (x_ff == LAST_COL) ? '0 : x_ff + COL_W'(1);
               if (addr_ff == LAST_ADDR) begin
                  run_in = 1'b0;
               end
            end else if (!s1_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            heat_in  = rd_ok_ff ? rd_data : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // write-back stage of the pass; targets the row above, never a pending read
      if (s1_valid_ff) begin
         if (rd_data == '0) begin
            wr_en   = 1'b1;
            wr_addr = s1_up_ff;
            wr_data = '0;
         end else begin
            rng_in  = rnd;
            wr_data = rd_data - HEAT_W'(rnd[0]);
            priority if (!rnd[2]) begin
               wr_en   = (s1_x_ff != LAST_COL);
               wr_addr = s1_up_ff + ADDR_W'(1);
            end else if (!rnd[1]) begin
               wr_en   = (s1_x_ff != '0);
               wr_addr = s1_up_ff - ADDR_W'(1);
            end else begin
               wr_en   = 1'b1;
               wr_addr = s1_up_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         addr_ff     <= '0;
         run_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
         rng_ff      <= RNG_SEED;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         run_ff      <= run_in;
         s1_valid_ff <= s1_valid_in;
         rng_ff      <= rng_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      s1_x_ff  <= s1_x_in;
      s1_up_ff <= s1_up_in;
      heat_ff  <= heat_in;
      rd_ok_ff <= rd_ok_in;
   end

endmodule

// ===== rtl/core/feg_checker.sv =====
`include "assert_macros.svh"

module feg_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input feg_pkg::feg_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input feg_pkg::feg_rsp_type rsp_data
);
   import feg_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   `FEG_ASSERT_RST(a_reset_quiet, reset, req_stall && !rsp_valid)
   `FEG_ASSERT_NEXT(a_one_in_flight, req_xfer, req_stall)
   `FEG_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data))
   `FEG_ASSERT_NOW(a_colour_matches, rsp_valid, rsp_data.color == feg_color(rsp_data.heat))
   `FEG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind fire_effect_grid feg_checker u_feg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
